/* rtl/toroidal_grid_row_col_rotate_unit_defines.svh */
// Assertion macros shared by the grid rotate unit RTL.
`ifndef TOROIDAL_GRID_ROW_COL_ROTATE_UNIT_DEFINES_SVH
`define TOROIDAL_GRID_ROW_COL_ROTATE_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TGRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TGRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tgrr_pkg.sv */
// Types and constants shared by the grid rotate unit.
package tgrr_pkg;

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 8;
    localparam int WORD_W    = 32;
    localparam int STEP_W    = $clog2(CNT_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ROT_ROW = 2'd2,
        OP_ROT_COL = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD1,
        S_MOD2,
        S_WRITE,
        S_RDISSUE,
        S_RDWAIT,
        S_LOAD,
        S_GAP,
        S_STORE,
        S_DRAIN,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [CNT_W-1:0] shift_count;
        logic [WORD_W-1:0] cell_data;
    } s_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              done_res;
    } m_item_t;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  dividend;
        logic [CFG_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } mod_rsp_t;

endpackage

/* rtl/tgrr_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module tgrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

/* rtl/tgrr_mod.sv */
// Iterative restoring remainder unit, one dividend bit per cycle.
`include "toroidal_grid_row_col_rotate_unit_defines.svh"

module tgrr_mod import tgrr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvd_reg, dvd_next;
    logic [CFG_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] left_reg, left_next;

    logic [CFG_W:0] shifted;
    logic [CFG_W:0] diff;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[CNT_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        left_next = left_reg;
        if (req.start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            left_next = req.steps;
        end else if (busy_reg) begin
            rem_next  = (shifted >= {1'b0, dvs_reg}) ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
            dvd_next  = {dvd_reg[CNT_W-2:0], 1'b0};
            left_next = left_reg - STEP_W'(1);
            if (left_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        left_reg <= left_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    `TGRR_ASSERT_SAME(a_busy_has_steps, busy_reg, left_reg != '0, "Busy with no steps left.")
    `TGRR_ASSERT_SAME(a_rem_below_divisor, busy_reg || done_reg, rem_reg < dvs_reg,
                      "Partial remainder reached the divisor.")
    `TGRR_ASSERT_NEXT(a_done_single_pulse, done_reg, !done_reg, "Done held for two cycles.")

endmodule

/* rtl/toroidal_grid_row_col_rotate_unit.sv */
// Top level of the grid rotate unit: control sequencer, grid and line buffer memories.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | s_item (op, indices, shift, data)
//   m_      | out       | m_valid / m_ready  | m_item (read_data, done_res)
//   cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One item is processed at a time; the remainder unit runs one bit per cycle.
// A rotation copies the line into the line buffer and writes it back rotated, one grid access per cycle.
// After reset a clearing pass writes zero to all MAX_ROWS * MAX_COLS cells, one a cycle.
// A result waiting in the output register holds the next item in its response state until it is taken.
`include "toroidal_grid_row_col_rotate_unit_defines.svh"

module toroidal_grid_row_col_rotate_unit import tgrr_pkg::*; #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  s_item_t              s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output m_item_t              m_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LINE_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int LW       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  rows_reg, rows_next;
    logic [CFG_W-1:0]  cols_reg, cols_next;
    s_item_t           item_reg, item_next;
    logic [CFG_W-1:0]  first_reg, first_next;
    logic [CFG_W-1:0]  second_reg, second_next;
    logic [CFG_W-1:0]  n_reg, n_next;
    logic [CFG_W-1:0]  j_reg, j_next;
    logic [CFG_W-1:0]  src_reg, src_next;
    logic              ld_wr_reg, ld_wr_next;
    logic [CFG_W-1:0]  ld_idx_reg, ld_idx_next;
    logic              st_wr_reg, st_wr_next;
    logic [CFG_W-1:0]  st_idx_reg, st_idx_next;
    logic [WORD_W-1:0] rd_reg, rd_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              m_valid_reg, m_valid_next;
    m_item_t           m_item_reg, m_item_next;

    logic [CFG_W-1:0]      rows_eff;
    logic [CFG_W-1:0]      cols_eff;
    mod_req_t              mreq;
    mod_rsp_t              mrsp;
    logic                  grid_we;
    logic [AW-1:0]         grid_addr;
    logic [DATA_WIDTH-1:0] grid_wdata;
    logic [DATA_WIDTH-1:0] grid_rdata;
    logic [DATA_WIDTH-1:0] lbuf_rdata;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int maxv);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (32'(v) > maxv) begin
            res = CFG_W'(maxv);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [CFG_W-1:0] row,
                                                input logic [CFG_W-1:0] col);
        return AW'(row) * AW'(MAX_COLS) + AW'(col);
    endfunction

    function automatic logic [AW-1:0] line_addr(input op_t op, input logic [CFG_W-1:0] line,
                                                input logic [CFG_W-1:0] pos);
        return (op == OP_ROT_ROW) ? cell_addr(line, pos) : cell_addr(pos, line);
    endfunction

    assign rows_eff = eff_dim(rows_reg, MAX_ROWS);
    assign cols_eff = eff_dim(cols_reg, MAX_COLS);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        item_next     = item_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        src_next      = src_reg;
        ld_wr_next    = (state_reg == S_LOAD);
        ld_idx_next   = j_reg;
        st_wr_next    = (state_reg == S_STORE);
        st_idx_next   = j_reg;
        rd_next       = rd_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        mreq          = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS: rows_next = cfg_wr_data;
                REG_COLS: cols_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_item;
                    rd_next    = '0;
                    mreq.start = 1'b1;
                    mreq.steps = STEP_W'(IDX_W);
                    if (s_item.op == OP_ROT_COL) begin
                        mreq.dividend = {s_item.col_index, {(CNT_W - IDX_W){1'b0}}};
                        mreq.divisor  = cols_eff;
                        n_next        = rows_eff;
                    end else begin
                        mreq.dividend = {s_item.row_index, {(CNT_W - IDX_W){1'b0}}};
                        mreq.divisor  = rows_eff;
                        n_next        = cols_eff;
                    end
                    state_next = S_MOD1;
                end
            end
            S_MOD1: begin
                if (mrsp.done) begin
                    first_next = mrsp.rem;
                    mreq.start = 1'b1;
                    case (item_reg.op)
                        OP_ROT_ROW: begin
                            mreq.dividend = item_reg.shift_count;
                            mreq.divisor  = cols_eff;
                            mreq.steps    = STEP_W'(CNT_W);
                        end
                        OP_ROT_COL: begin
                            mreq.dividend = item_reg.shift_count;
                            mreq.divisor  = rows_eff;
                            mreq.steps    = STEP_W'(CNT_W);
                        end
                        default: begin
                            mreq.dividend = {item_reg.col_index, {(CNT_W - IDX_W){1'b0}}};
                            mreq.divisor  = cols_eff;
                            mreq.steps    = STEP_W'(IDX_W);
                        end
                    endcase
                    state_next = S_MOD2;
                end
            end
            S_MOD2: begin
                if (mrsp.done) begin
                    second_next = mrsp.rem;
                    case (item_reg.op)
                        OP_WRITE: state_next = S_WRITE;
                        OP_READ:  state_next = S_RDISSUE;
                        default: begin
                            if (mrsp.rem == '0) begin
                                state_next = S_RESP;
                            end else begin
                                j_next     = '0;
                                src_next   = n_reg - mrsp.rem;
                                state_next = S_LOAD;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: state_next = S_RESP;
            S_RDISSUE: state_next = S_RDWAIT;
            S_RDWAIT: begin
                rd_next    = WORD_W'(grid_rdata);
                state_next = S_RESP;
            end
            S_LOAD: begin
                j_next = j_reg + CFG_W'(1);
                if (j_reg == n_reg - CFG_W'(1)) begin
                    j_next     = '0;
                    state_next = S_GAP;
                end
            end
            S_GAP: state_next = S_STORE;
            S_STORE: begin
                j_next   = j_reg + CFG_W'(1);
                src_next = (src_reg == n_reg - CFG_W'(1)) ? '0 : src_reg + CFG_W'(1);
                if (j_reg == n_reg - CFG_W'(1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_RESP;
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_item_next.read_data = rd_reg;
                    m_item_next.done_res  = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        grid_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE) || st_wr_reg;
        grid_addr  = cell_addr(first_reg, second_reg);
        grid_wdata = DATA_WIDTH'(item_reg.cell_data);
        if (state_reg == S_CLEAR) begin
            grid_addr  = clr_addr_reg;
            grid_wdata = '0;
        end else if (st_wr_reg) begin
            grid_addr  = line_addr(item_reg.op, first_reg, st_idx_reg);
            grid_wdata = lbuf_rdata;
        end else if (state_reg == S_LOAD) begin
            grid_addr = line_addr(item_reg.op, first_reg, j_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            rows_reg     <= DIM_RESET;
            cols_reg     <= DIM_RESET;
            ld_wr_reg    <= 1'b0;
            st_wr_reg    <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            ld_wr_reg    <= ld_wr_next;
            st_wr_reg    <= st_wr_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
        item_reg   <= item_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        n_reg      <= n_next;
        j_reg      <= j_next;
        src_reg    <= src_next;
        ld_idx_reg <= ld_idx_next;
        st_idx_reg <= st_idx_next;
        rd_reg     <= rd_next;
        m_item_reg <= m_item_next;
    end

    tgrr_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    tgrr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (grid_addr),
        .wdata (grid_wdata),
        .raddr (grid_addr),
        .rdata (grid_rdata)
    );

    tgrr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (LINE_MAX)
    ) u_line (
        .aclk  (aclk),
        .we    (ld_wr_reg),
        .waddr (LW'(ld_idx_reg)),
        .wdata (grid_rdata),
        .raddr (LW'(src_reg)),
        .rdata (lbuf_rdata)
    );

    `TGRR_ASSERT_SAME(a_lbuf_phases_apart, ld_wr_reg, !st_wr_reg,
                      "Line buffer fill and drain overlap.")
    `TGRR_ASSERT_SAME(a_src_in_line, state_reg == S_STORE, src_reg < n_reg,
                      "Line buffer source index left the line.")
    `TGRR_ASSERT_SAME(a_no_write_in_load, state_reg == S_LOAD, !grid_we,
                      "Grid written while a line is being read.")

endmodule

/* tb/toroidal_grid_row_col_rotate_unit_tb.sv */
// Testbench for the grid rotate unit: random and directed beats checked against a grid mirror.
`timescale 1ns / 1ps

module toroidal_grid_row_col_rotate_unit_tb import tgrr_pkg::*;;

    localparam int GRID_DIM    = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 80;
    localparam int PHASES      = 10;

    class grid_mirror;
        logic [WORD_W-1:0] cells [GRID_DIM][GRID_DIM];
        logic [CFG_W-1:0]  row_count;
        logic [CFG_W-1:0]  col_count;
        m_item_t           pending_words[$];
        int                mismatches;

        function new();
            foreach (cells[r, c]) cells[r][c] = '0;
            row_count  = DIM_RESET;
            col_count  = DIM_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_ROWS) begin
                row_count = value;
            end else begin
                col_count = value;
            end
        endfunction

        function int active_dim(logic [CFG_W-1:0] value);
            if (value == 0) return 1;
            if (value > GRID_DIM) return GRID_DIM;
            return int'(value);
        endfunction

        function void apply_item(s_item_t it);
            int nr;
            int nc;
            int r;
            int c;
            int k;
            logic [WORD_W-1:0] line_words [GRID_DIM];
            m_item_t result;
            nr = active_dim(row_count);
            nc = active_dim(col_count);
            r  = int'(it.row_index) % nr;
            c  = int'(it.col_index) % nc;
            result.read_data = '0;
            result.done_res  = 1'b1;
            case (it.op)
                OP_WRITE: begin
                    cells[r][c] = it.cell_data;
                end
                OP_READ: begin
                    result.read_data = cells[r][c];
                end
                OP_ROT_ROW: begin
                    k = int'(it.shift_count) % nc;
                    if (nc > 1 && k != 0) begin
                        for (int j = 0; j < nc; j++) line_words[j] = cells[r][j];
                        for (int j = 0; j < nc; j++) cells[r][j] = line_words[(j + nc - k) % nc];
                    end
                end
                default: begin
                    k = int'(it.shift_count) % nr;
                    if (nr > 1 && k != 0) begin
                        for (int j = 0; j < nr; j++) line_words[j] = cells[j][c];
                        for (int j = 0; j < nr; j++) cells[j][c] = line_words[(j + nr - k) % nr];
                    end
                end
            endcase
            pending_words.push_back(result);
        endfunction

        function void check_result(m_item_t got);
            m_item_t want;
            if (pending_words.size() == 0) begin
                $error("result beat with nothing expected: read_data %h", got.read_data);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
                mismatches++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %b, actual %b", want.done_res, got.done_res);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    s_item_t              s_item;
    logic                 m_valid;
    logic                 m_ready;
    m_item_t              m_item;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    grid_mirror mirror;
    bit         idle_on;
    bit         hold_req;
    int         quiet_cycles = 0;

    toroidal_grid_row_col_rotate_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic s_item_t make_item(op_t op, int row, int col, int shift,
                                          logic [WORD_W-1:0] data);
        s_item_t it;
        it.op          = op;
        it.row_index   = IDX_W'(row);
        it.col_index   = IDX_W'(col);
        it.shift_count = CNT_W'(shift);
        it.cell_data   = data;
        return it;
    endfunction

    function automatic s_item_t random_item();
        int   pick;
        op_t  op;
        int   shift;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            op = OP_WRITE;
        end else if (pick < 6) begin
            op = OP_READ;
        end else if (pick < 8) begin
            op = OP_ROT_ROW;
        end else begin
            op = OP_ROT_COL;
        end
        shift = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255);
        return make_item(op, $urandom_range(0, 15), $urandom_range(0, 15), shift, $urandom);
    endfunction

    task automatic send_item(input s_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        mirror.apply_item(it);
        @(negedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        mirror.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (mirror.pending_words.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int stall;
        bit held;
        held = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            mirror.check_result(m_item);
            @(negedge aclk);
        end
    end

    initial begin
        int row_cfg [PHASES];
        int col_cfg [PHASES];
        mirror       = new();
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_item       <= '0;
        m_ready      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_ROWS;
        cfg_wr_data  <= '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full 16 by 16 grid: corners, data extremes, null and wrapping rotations.
        send_item(make_item(OP_WRITE, 0, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(OP_WRITE, 15, 15, 255, 32'h5A5A_A5A5));
        send_item(make_item(OP_WRITE, 0, 15, 255, 32'h0000_0000));
        send_item(make_item(OP_WRITE, 15, 0, 0, 32'h8000_0001));
        send_item(make_item(OP_READ, 0, 0, 0, 32'hFFFF_FFFF));
        send_item(make_item(OP_READ, 15, 15, 0, 32'h0));
        send_item(make_item(OP_ROT_ROW, 0, 0, 0, 32'h0));
        send_item(make_item(OP_READ, 0, 0, 0, 32'h0));
        send_item(make_item(OP_ROT_ROW, 0, 0, 1, 32'h0));
        send_item(make_item(OP_READ, 0, 1, 0, 32'h0));
        send_item(make_item(OP_ROT_ROW, 0, 0, 255, 32'h0));
        send_item(make_item(OP_READ, 0, 0, 0, 32'h0));
        send_item(make_item(OP_ROT_COL, 0, 0, 16, 32'h0));
        send_item(make_item(OP_ROT_COL, 0, 0, 3, 32'h0));
        send_item(make_item(OP_READ, 3, 0, 0, 32'h0));
        send_item(make_item(OP_ROT_COL, 0, 15, 255, 32'h0));
        send_item(make_item(OP_READ, 14, 15, 0, 32'h0));
        settle();

        // Counts of zero and 31 act as one row and sixteen columns.
        program_reg(REG_ROWS, CFG_W'(0));
        program_reg(REG_COLS, CFG_W'(31));
        send_item(make_item(OP_WRITE, 9, 3, 0, 32'hC0DE_0003));
        send_item(make_item(OP_ROT_COL, 2, 3, 7, 32'h0));
        send_item(make_item(OP_ROT_ROW, 12, 0, 17, 32'h0));
        send_item(make_item(OP_READ, 5, 4, 0, 32'h0));
        settle();

        row_cfg = '{16, 1, 1, 16, 4, 3, 0, 31, 17, 0};
        col_cfg = '{16, 1, 16, 1, 4, 5, 0, 31, 2, 0};
        row_cfg[PHASES-1] = $urandom_range(0, 31);
        col_cfg[PHASES-1] = $urandom_range(0, 31);
        for (int p = 0; p < PHASES; p++) begin
            idle_on  = (p % 3 != 1);
            hold_req = (p == 2);
            program_reg(REG_ROWS, CFG_W'(row_cfg[p]));
            program_reg(REG_COLS, CFG_W'(col_cfg[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
            settle();
        end

        repeat (20) @(negedge aclk);
        if (mirror.mismatches == 0 && mirror.pending_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
